// ===== design/ir_pulse_width_capture_top_assert.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef IR_PULSE_WIDTH_CAPTURE_TOP_ASSERT_SVH
`define IR_PULSE_WIDTH_CAPTURE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPWC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IPWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipwc_pkg.sv =====
`default_nettype none
package ipwc_pkg;

  localparam int TICK_COUNTER_WIDTH_DEF = 24;
  localparam int MAX_PULSE_LIMIT_DEF    = 1024;

  localparam int TIMEOUT_W = 24;
  localparam int COUNT_W   = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [TIMEOUT_W-1:0] FIRST_TIMEOUT_RST = 24'd10000000;
  localparam logic [TIMEOUT_W-1:0] END_TIMEOUT_RST   = 24'd1000000;
  localparam logic [COUNT_W-1:0]   MAX_PULSES_RST    = 11'd1024;
  localparam logic [TIMEOUT_W-1:0] FIELD_MAX         = '1;

  // input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_TIMEOUT = 2'd0,
    REG_END_TIMEOUT   = 2'd1,
    REG_MAX_PULSES    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_PULSE     = 2'd0,
    EV_SILENCE   = 2'd1,
    EV_NO_SIGNAL = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] wait_limit;
    logic [TIMEOUT_W-1:0] silence_limit;
    logic [COUNT_W-1:0]   max_pulses;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           event_kind;
    logic [TIMEOUT_W-1:0] pulse_ticks;
    logic                 pulse_level;
    logic [COUNT_W-1:0]   pulses_so_far;
    logic                 last;
  } result_t;

endpackage
`default_nettype wire

// ===== design/ir_pulse_width_capture_top.sv =====
// A result appears on out_valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless in_stall; armed ticks step the counter.
// in_stall is high only while a finished result waits in the output register.
// Reset (rst, synchronous): idle, no capture armed, output empty,
// timeouts and pulse limit back to their default values.
`default_nettype none
module ir_pulse_width_capture_top #(
  parameter int TICK_COUNTER_WIDTH = ipwc_pkg::TICK_COUNTER_WIDTH_DEF,
  parameter int MAX_PULSE_LIMIT    = ipwc_pkg::MAX_PULSE_LIMIT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write port
  input  wire logic                            cfg_we,
  input  wire logic [ipwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipwc_pkg::TIMEOUT_W-1:0]  cfg_data,
  // input item channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            opcode,
  input  wire logic                            ir_level,
  // result item channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           event_kind,
  output logic [ipwc_pkg::TIMEOUT_W-1:0]       pulse_ticks,
  output logic                                 pulse_level,
  output logic [ipwc_pkg::COUNT_W-1:0]         pulses_so_far,
  output logic                                 last
);
  import ipwc_pkg::*;
  `include "ir_pulse_width_capture_top_assert.svh"

  cfg_t    cfg;
  result_t res;
  result_t held;
  logic    res_valid;
  logic    accept;

  // Items are taken unless a result is parked and the consumer holds it.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  ipwc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // capture state machine: phase, tick counter, last level, pulse count
  ipwc_core #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH),
    .MAX_PULSE_LIMIT    (MAX_PULSE_LIMIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (accept),
    .opcode    (opcode),
    .ir_level  (ir_level),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register; holds a result while the consumer stalls
  ipwc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign event_kind    = held.event_kind;
  assign pulse_ticks   = held.pulse_ticks;
  assign pulse_level   = held.pulse_level;
  assign pulses_so_far = held.pulses_so_far;
  assign last          = held.last;

  // Timeout results always close the capture.
  `IPWC_ASSERT_NOW(a_timeout_last, clk, rst,
    out_valid && (event_kind == EV_SILENCE || event_kind == EV_NO_SIGNAL),
    last == 1'b1 && pulse_ticks == '0 && pulse_level == 1'b0,
    "timeout result without last or with pulse data")
  // No-signal timeout happens before any pulse is counted.
  `IPWC_ASSERT_NOW(a_nosig_zero, clk, rst,
    out_valid && event_kind == EV_NO_SIGNAL,
    pulses_so_far == '0,
    "no-signal timeout with nonzero pulse count")
  // A measured pulse lasts at least one tick and is counted.
  `IPWC_ASSERT_NOW(a_pulse_nonzero, clk, rst,
    out_valid && event_kind == EV_PULSE,
    pulse_ticks != '0 && pulses_so_far != '0,
    "pulse result with zero duration or zero count")
  // A held result that was not taken is still there next cycle.
  `IPWC_ASSERT_NEXT(a_held_result, clk, rst,
    out_valid && out_stall,
    out_valid && $stable(pulse_ticks) && $stable(event_kind),
    "parked result lost or changed")

endmodule
`default_nettype wire

// ===== design/ipwc_cfg.sv =====
`default_nettype none
module ipwc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ipwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ipwc_pkg::TIMEOUT_W-1:0]  cfg_data,
  output ipwc_pkg::cfg_t                       cfg
);
  import ipwc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_limit    <= FIRST_TIMEOUT_RST;
      cfg.silence_limit <= END_TIMEOUT_RST;
      cfg.max_pulses    <= MAX_PULSES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_TIMEOUT: cfg.wait_limit    <= cfg_data;
        REG_END_TIMEOUT:   cfg.silence_limit <= cfg_data;
        REG_MAX_PULSES:    cfg.max_pulses    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/ipwc_core.sv =====
`default_nettype none
module ipwc_core #(
  parameter int TICK_COUNTER_WIDTH = ipwc_pkg::TICK_COUNTER_WIDTH_DEF,
  parameter int MAX_PULSE_LIMIT    = ipwc_pkg::MAX_PULSE_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ipwc_pkg::cfg_t cfg,
  input  wire logic        step,
  input  wire logic        opcode,
  input  wire logic        ir_level,
  output logic             res_valid,
  output ipwc_pkg::result_t res
);
  import ipwc_pkg::*;

  localparam int TW = TICK_COUNTER_WIDTH;
  // compare width wide enough for both the counter and the 24-bit fields
  localparam int CW = (TW > TIMEOUT_W) ? TW : TIMEOUT_W;
  localparam int PW = $clog2(MAX_PULSE_LIMIT + 1);
  localparam int LW = (PW > COUNT_W) ? PW : COUNT_W;
  localparam logic [TW-1:0] TICK_MAX = '1;
  localparam logic [LW-1:0] PULSE_LIM = LW'(MAX_PULSE_LIMIT);

  typedef enum logic [1:0] {
    IDLE       = 2'd0,
    WAIT_FIRST = 2'd1,
    CAPTURE    = 2'd2
  } phase_t;

  phase_t        phase, phase_next;
  logic [TW-1:0] ticks, ticks_next;
  logic          prev_level, prev_level_next;
  logic [PW-1:0] count, count_next;

  logic [TW-1:0] tick_inc;
  logic [CW-1:0] tick_inc_ext, first_lim, end_lim, dur_ext;
  logic [LW-1:0] lim, count_inc_ext, count_ext;
  logic [PW-1:0] count_inc;

  always_comb begin
    // saturating counter step
    tick_inc     = (ticks == TICK_MAX) ? ticks : ticks + 1'b1;
    tick_inc_ext = CW'(tick_inc);
    first_lim    = (CW'(cfg.wait_limit) < CW'(TICK_MAX)) ?
                   CW'(cfg.wait_limit) : CW'(TICK_MAX);
    end_lim      = (CW'(cfg.silence_limit) < CW'(TICK_MAX)) ?
                   CW'(cfg.silence_limit) : CW'(TICK_MAX);
    // pulse length is samples since edge plus one, saturating
    dur_ext      = CW'(tick_inc);
    // pulse limit clamped into 1..MAX_PULSE_LIMIT
    if (cfg.max_pulses == '0) begin
      lim = LW'(1);
    end else if (LW'(cfg.max_pulses) > PULSE_LIM) begin
      lim = PULSE_LIM;
    end else begin
      lim = LW'(cfg.max_pulses);
    end
    count_inc     = count + 1'b1;
    count_inc_ext = LW'(count_inc);
    count_ext     = LW'(count);

    phase_next      = phase;
    ticks_next      = ticks;
    prev_level_next = prev_level;
    count_next      = count;
    res_valid       = 1'b0;
    res.event_kind    = EV_PULSE;
    res.pulse_ticks   = '0;
    res.pulse_level   = 1'b0;
    res.pulses_so_far = count_ext[COUNT_W-1:0];
    res.last          = 1'b1;

    if (opcode == OP_ARM) begin
      phase_next      = WAIT_FIRST;
      ticks_next      = '0;
      prev_level_next = 1'b1;
      count_next      = '0;
    end else begin
      case (phase)
        WAIT_FIRST: begin
          if (ir_level) begin
            phase_next      = CAPTURE;
            ticks_next      = '0;
            prev_level_next = 1'b1;
          end else begin
            ticks_next = tick_inc;
            if (tick_inc_ext >= first_lim) begin
              phase_next     = IDLE;
              res_valid      = 1'b1;
              res.event_kind = EV_NO_SIGNAL;
            end
          end
        end
        CAPTURE: begin
          if (ir_level == prev_level) begin
            ticks_next = tick_inc;
            if (tick_inc_ext >= end_lim) begin
              phase_next     = IDLE;
              res_valid      = 1'b1;
              res.event_kind = EV_SILENCE;
            end
          end else begin
            res_valid         = 1'b1;
            res.event_kind    = EV_PULSE;
            res.pulse_ticks   = (dur_ext > CW'(FIELD_MAX)) ?
                                FIELD_MAX : dur_ext[TIMEOUT_W-1:0];
            res.pulse_level   = prev_level;
            res.pulses_so_far = count_inc_ext[COUNT_W-1:0];
            res.last          = (count_inc_ext >= lim);
            count_next        = count_inc;
            prev_level_next   = ir_level;
            ticks_next        = '0;
            if (count_inc_ext >= lim) begin
              phase_next = IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= IDLE;
      ticks      <= '0;
      prev_level <= 1'b1;
      count      <= '0;
    end else if (step) begin
      phase      <= phase_next;
      ticks      <= ticks_next;
      prev_level <= prev_level_next;
      count      <= count_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/ipwc_out.sv =====
`default_nettype none
module ipwc_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire ipwc_pkg::result_t res,
  input  wire logic          out_stall,
  output logic               out_valid,
  output ipwc_pkg::result_t  held
);
  import ipwc_pkg::*;

  // a held result stays until it is taken; a new one may replace it
  // in the cycle it leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule
`default_nettype wire

// ===== verif/ir_pulse_width_capture_top_tb.sv =====
`timescale 1ns / 1ps

// Testbench for ir_pulse_width_capture_top.
//
// Input items are queued by the stimulus process and presented by a clocked driver.
// Every accepted item goes through a local model of the capture logic. Any result
// it produces is pushed onto expected_events. A clocked monitor pops that queue for
// each accepted result item and compares it field by field.
//
// Both channels insert random idle bursts. The last phase runs without any idling.
// Register writes happen only while the block is quiet: the input queue is drained,
// no result is outstanding, and a drain wait has passed for items that produce no
// result.
module ir_pulse_width_capture_top_tb;
  import ipwc_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 4;    // result shows up in the cycle after its item is accepted
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000; // limit on quiet cycles before the run is failed

  typedef struct packed {
    logic op;
    logic lvl;
  } ir_item_t;

  typedef enum logic [1:0] {
    CAP_IDLE,
    CAP_WAIT_FIRST,
    CAP_MEASURE
  } capture_phase_t;

  // DUT inputs, known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIMEOUT_W-1:0] cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 opcode    = OP_TICK;
  logic                 ir_level  = 1'b0;
  logic                 out_stall = 1'b0;

  // DUT outputs
  logic                 in_stall;
  logic                 out_valid;
  logic [1:0]           event_kind;
  logic [TIMEOUT_W-1:0] pulse_ticks;
  logic                 pulse_level;
  logic [COUNT_W-1:0]   pulses_so_far;
  logic                 last;

  ir_pulse_width_capture_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .ir_level      (ir_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .pulse_ticks   (pulse_ticks),
    .pulse_level   (pulse_level),
    .pulses_so_far (pulses_so_far),
    .last          (last)
  );

  always #CLK_HALF clk = ~clk;

  // Item queues and bookkeeping
  ir_item_t ir_items_pending[$];
  result_t  expected_events[$];
  int       items_queued    = 0;
  int       items_accepted  = 0;
  int       events_checked  = 0;
  int       error_count     = 0;
  int       config_settings = 0;
  int       quiet_cycles    = 0;

  // Idle burst odds in percent, changed per phase
  int gap_pct   = 0;
  int stall_pct = 0;
  int gap_left   = 0;
  int stall_left = 0;

  // Register values that the stimulus shapes its captures around
  int stim_first = int'(FIRST_TIMEOUT_RST);
  int stim_end   = int'(END_TIMEOUT_RST);

  // Capture model: its own copy of the registers and of the state
  logic [TIMEOUT_W-1:0] cap_first_to  = FIRST_TIMEOUT_RST;
  logic [TIMEOUT_W-1:0] cap_end_to    = END_TIMEOUT_RST;
  logic [COUNT_W-1:0]   cap_pulse_max = MAX_PULSES_RST;
  capture_phase_t       cap_phase     = CAP_IDLE;
  logic [TIMEOUT_W-1:0] cap_ticks     = '0;
  logic                 cap_prev      = 1'b1;
  logic [COUNT_W-1:0]   cap_count     = '0;

  function automatic result_t make_event(event_kind_t kind, logic [TIMEOUT_W-1:0] ticks,
                                         logic lvl, logic [COUNT_W-1:0] n, logic fin);
    result_t r;
    r.event_kind    = kind;
    r.pulse_ticks   = ticks;
    r.pulse_level   = lvl;
    r.pulses_so_far = n;
    r.last          = fin;
    return r;
  endfunction

  // Step the capture model by one accepted item.
  task automatic capture_predict(logic op, logic lvl);
    logic [TIMEOUT_W:0]   dur;
    logic [COUNT_W-1:0]   lim;
    logic                 held;
    logic                 fin;
    if (op == OP_ARM) begin
      // an arm always restarts from scratch, even mid-capture
      cap_phase = CAP_WAIT_FIRST;
      cap_ticks = '0;
      cap_prev  = 1'b1;
      cap_count = '0;
    end else if (cap_phase == CAP_WAIT_FIRST) begin
      if (lvl) begin
        cap_phase = CAP_MEASURE;
        cap_ticks = '0;
        cap_prev  = 1'b1;
      end else begin
        if (cap_ticks != FIELD_MAX) cap_ticks = cap_ticks + 1'b1;
        if (cap_ticks >= cap_first_to) begin
          cap_phase = CAP_IDLE;
          expected_events.push_back(make_event(EV_NO_SIGNAL, '0, 1'b0, cap_count, 1'b1));
        end
      end
    end else if (cap_phase == CAP_MEASURE) begin
      if (lvl == cap_prev) begin
        if (cap_ticks != FIELD_MAX) cap_ticks = cap_ticks + 1'b1;
        if (cap_ticks >= cap_end_to) begin
          cap_phase = CAP_IDLE;
          expected_events.push_back(make_event(EV_SILENCE, '0, 1'b0, cap_count, 1'b1));
        end
      end else begin
        // duration counts the edge sample itself; saturate at the field width
        dur = {1'b0, cap_ticks} + 1'b1;
        if (dur > {1'b0, FIELD_MAX}) dur = {1'b0, FIELD_MAX};
        lim = cap_pulse_max;
        if (lim == '0) lim = COUNT_W'(1);
        if (lim > COUNT_W'(MAX_PULSE_LIMIT_DEF)) lim = COUNT_W'(MAX_PULSE_LIMIT_DEF);
        held      = cap_prev;
        cap_count = cap_count + 1'b1;
        fin       = (cap_count >= lim);
        cap_prev  = lvl;
        cap_ticks = '0;
        if (fin) cap_phase = CAP_IDLE;
        expected_events.push_back(make_event(EV_PULSE, dur[TIMEOUT_W-1:0], held,
                                             cap_count, fin));
      end
    end
    // ticks while idle are ignored
  endtask

  // Driver: retire the accepted item, then present the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        capture_predict(opcode, ir_level);
        items_accepted <= items_accepted + 1;
      end
      // a stalled item is held as is
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (ir_items_pending.size() != 0 && gap_pct > 0 &&
                     $urandom_range(0, 99) < gap_pct) begin
          gap_left <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (ir_items_pending.size() != 0) begin
          ir_item_t nxt;
          nxt = ir_items_pending.pop_front();
          in_valid <= 1'b1;
          opcode   <= nxt.op;
          ir_level <= nxt.lvl;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then decide the stall for next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          if (error_count < 10)
            $display("[%0t] unexpected result: kind=%0d ticks=%0d lvl=%0d count=%0d last=%0d",
                     $realtime, event_kind, pulse_ticks, pulse_level, pulses_so_far, last);
          error_count <= error_count + 1;
        end else begin
          result_t want;
          want = expected_events.pop_front();
          events_checked <= events_checked + 1;
          if (event_kind !== want.event_kind || pulse_ticks !== want.pulse_ticks ||
              pulse_level !== want.pulse_level || pulses_so_far !== want.pulses_so_far ||
              last !== want.last) begin
            if (error_count < 10) begin
              $display("[%0t] mismatch: expected kind=%0d ticks=%0d lvl=%0d count=%0d last=%0d",
                       $realtime, want.event_kind, want.pulse_ticks, want.pulse_level,
                       want.pulses_so_far, want.last);
              $display("             got      kind=%0d ticks=%0d lvl=%0d count=%0d last=%0d",
                       event_kind, pulse_ticks, pulse_level, pulses_so_far, last);
            end
            error_count <= error_count + 1;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left <= $urandom_range(0, 16);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles in a row with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] timed out: no item moved for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, expected_events.size());
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(logic op, logic lvl);
    ir_item_t it;
    it.op  = op;
    it.lvl = lvl;
    ir_items_pending.push_back(it);
    items_queued++;
  endtask

  // Wait until every queued item is accepted and every result is back, then
  // give zero-result items time to leave the pipe.
  task automatic settle();
    while (ir_items_pending.size() != 0 || in_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [TIMEOUT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIRST_TIMEOUT: cap_first_to  = val;
      REG_END_TIMEOUT:   cap_end_to    = val;
      REG_MAX_PULSES:    cap_pulse_max = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int first_to, int end_to, int pulse_max);
    settle();
    write_reg(REG_FIRST_TIMEOUT, TIMEOUT_W'(first_to));
    write_reg(REG_END_TIMEOUT, TIMEOUT_W'(end_to));
    write_reg(REG_MAX_PULSES, TIMEOUT_W'(pulse_max));
    stim_first = first_to;
    stim_end   = end_to;
    config_settings++;
  endtask

  // One well-formed capture with random content: arm, some low lead-in,
  // a first high, then pulses kept shorter than the silence limit.
  // Sometimes it runs into a no-signal timeout, a silence end, or a re-arm.
  task automatic queue_capture();
    int  lead;
    int  npulse;
    int  hold;
    int  k;
    int  j;
    logic lvl;
    push_item(OP_ARM, 1'($urandom));
    if ($urandom_range(0, 7) == 0 && stim_first <= 40) begin
      for (k = 0; k < stim_first || k == 0; k++) push_item(OP_TICK, 1'b0);
      // trailing ticks land on an idle block
      for (k = $urandom_range(0, 2); k > 0; k--) push_item(OP_TICK, 1'($urandom));
      return;
    end
    lead = (stim_first > 0) ? $urandom_range(0, (stim_first > 5) ? 4 : stim_first - 1) : 0;
    for (k = 0; k < lead; k++) push_item(OP_TICK, 1'b0);
    push_item(OP_TICK, 1'b1);
    lvl    = 1'b1;
    npulse = $urandom_range(1, 10);
    for (k = 0; k < npulse; k++) begin
      hold = (stim_end > 0) ? $urandom_range(0, (stim_end > 6) ? 5 : stim_end - 1) : 0;
      for (j = 0; j < hold; j++) push_item(OP_TICK, lvl);
      lvl = ~lvl;
      push_item(OP_TICK, lvl);
      if ($urandom_range(0, 40) == 0) push_item(OP_ARM, 1'($urandom));
    end
    if ($urandom_range(0, 2) == 0 && stim_end <= 40) begin
      for (j = 0; j < stim_end || j == 0; j++) push_item(OP_TICK, lvl);
    end
  endtask

  // A phase of captures mixed with noise items under one register setting.
  task automatic run_phase(int first_to, int end_to, int pulse_max, int n_items,
                           int gap, int stall);
    int stop_at;
    int k;
    set_config(first_to, end_to, pulse_max);
    gap_pct   = gap;
    stall_pct = stall;
    stop_at   = items_queued + n_items;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) begin
        for (k = $urandom_range(1, 3); k > 0; k--)
          push_item(($urandom_range(0, 3) == 0) ? OP_ARM : OP_TICK, 1'($urandom));
      end else begin
        queue_capture();
      end
    end
  endtask

  initial begin
    int k;
    logic lvl;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Reset register values first: a tick before any arm is
    // ignored, two pulses are measured, then an arm lands mid-capture.
    gap_pct   = 10;
    stall_pct = 10;
    push_item(OP_TICK, 1'b1);
    push_item(OP_ARM, 1'b0);
    push_item(OP_TICK, 1'b1);
    push_item(OP_TICK, 1'b0);
    push_item(OP_TICK, 1'b0);
    push_item(OP_TICK, 1'b1);
    push_item(OP_ARM, 1'b1);

    // Small limits: no-signal timeout, pulse limit reached, end by silence.
    set_config(3, 2, 3);
    push_item(OP_ARM, 1'b0);
    repeat (3) push_item(OP_TICK, 1'b0);
    push_item(OP_ARM, 1'b1);
    push_item(OP_TICK, 1'b1);
    push_item(OP_TICK, 1'b0);
    push_item(OP_TICK, 1'b1);
    push_item(OP_TICK, 1'b0);
    push_item(OP_ARM, 1'b0);
    repeat (3) push_item(OP_TICK, 1'b1);

    // Zero timeouts fire on the first counting tick; a zero pulse limit acts as one.
    set_config(0, 0, 0);
    push_item(OP_ARM, 1'b1);
    push_item(OP_TICK, 1'b0);
    push_item(OP_ARM, 1'b0);
    push_item(OP_TICK, 1'b1);
    push_item(OP_TICK, 1'b1);
    push_item(OP_ARM, 1'b1);
    push_item(OP_TICK, 1'b1);
    push_item(OP_TICK, 1'b0);
    push_item(OP_TICK, 1'b0);

    // Random part
    run_phase(1, 1, 1, 60, 10, 10);
    run_phase(5, 8, 4, 80, 8, 0);
    run_phase(20, 12, 10, 80, 0, 12);
    run_phase($urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(1, 16), 100, 6, 6);

    // Top register values; the pulse limit register is above its maximum and
    // clamps, so a run of single-tick pulses keeps the capture open.
    set_config(int'(FIELD_MAX), int'(FIELD_MAX), 2047);
    gap_pct   = 4;
    stall_pct = 4;
    push_item(OP_ARM, 1'b0);
    push_item(OP_TICK, 1'b1);
    lvl = 1'b1;
    for (k = 0; k < 30; k++) begin
      lvl = ~lvl;
      push_item(OP_TICK, lvl);
    end
    repeat (2) queue_capture();

    run_phase($urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(1, 16), 60, 6, 6);
    // last stretch runs with no idling on either side
    run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 8), 80, 0, 0);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d input items (arms, ticks, idle ticks) over %0d register settings;",
             items_accepted, config_settings);
    $display("checked %0d capture events, %0d errors.", events_checked, error_count);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
